// File: rtl/bbcp_pkg.sv
// Shared types, codes and constants of the block buffer cache policy.
`timescale 1ns / 1ps
package bbcp_pkg;

    localparam int BLOCK_BITS     = 32;
    localparam int NUM_SLOTS_DEF  = 16;
    localparam int AGE_BITS       = 16;
    localparam int REF_BITS       = 8;
    localparam int MAX_HELD_BITS  = 5;
    localparam int CFG_INDEX_BITS = 4;
    localparam int CFG_DATA_BITS  = 8;
    localparam int MAX_OUT        = 16;
    localparam int FLUSH_CNT_BITS = 5;

    localparam logic [MAX_HELD_BITS-1:0] MAX_HELD_RST = 5'd8;

    localparam logic [1:0] L_FREE   = 2'd0;
    localparam logic [1:0] L_ACTIVE = 2'd1;
    localparam logic [1:0] L_CLEAN  = 2'd2;
    localparam logic [1:0] L_DIRTY  = 2'd3;

    localparam logic [1:0] OP_REQUEST = 2'd0;
    localparam logic [1:0] OP_RELEASE = 2'd1;
    localparam logic [1:0] OP_FLUSH   = 2'd2;

    localparam logic [CFG_INDEX_BITS-1:0] CFG_MAX_HELD = 4'd0;
    localparam logic [CFG_INDEX_BITS-1:0] CFG_NO_LOCAL = 4'd1;

    localparam logic [3:0] ST_SHARED_HIT  = 4'd0;
    localparam logic [3:0] ST_CLEAN_HIT   = 4'd1;
    localparam logic [3:0] ST_DIRTY_HIT   = 4'd2;
    localparam logic [3:0] ST_FETCHED     = 4'd3;
    localparam logic [3:0] ST_STILL_REF   = 4'd4;
    localparam logic [3:0] ST_PARK_CLEAN  = 4'd5;
    localparam logic [3:0] ST_PARK_DIRTY  = 4'd6;
    localparam logic [3:0] ST_WRITTEN     = 4'd7;
    localparam logic [3:0] ST_NO_SLOT     = 4'd8;
    localparam logic [3:0] ST_UNKNOWN     = 4'd9;
    localparam logic [3:0] ST_FLUSH_EMPTY = 4'd10;

    typedef struct packed {
        logic [1:0]            op;
        logic [BLOCK_BITS-1:0] block_number;
        logic                  read_from_media;
        logic                  dirty;
    } in_item_t;

    typedef struct packed {
        logic [3:0]            status;
        logic                  dirty_out;
        logic                  fetch_valid;
        logic                  fetch_read;
        logic                  writeback_valid;
        logic [BLOCK_BITS-1:0] writeback_block;
        logic                  writeback_modified;
        logic [REF_BITS-1:0]   ref_count;
        logic                  last;
    } out_item_t;

    typedef struct packed {
        logic load;
        logic scan_init;
        logic scan_step;
        logic apply;
        logic age_assign;
        logic rn_init;
        logic rn_load;
        logic rn_cmp;
        logic rn_copy;
        logic push;
        logic fl_init;
        logic fl_take;
        logic fl_pass;
        logic fl_push;
        logic fl_end;
    } cmd_t;

    typedef struct packed {
        logic [1:0] op;
        logic       idx_last;
        logic       ri_last;
        logic       need_age;
        logic       age_wrap;
        logic       fl_found;
        logic       fl_pend;
        logic       fl_k_full;
        logic       fl_pass_dirty;
        logic       out_free;
    } stat_t;

endpackage

// File: rtl/block_buffer_cache_policy.sv
// Top level of the block buffer cache policy: controller, datapath and ports.
// A request or release scans every slot, one slot per cycle.
// A flush rescans all slots for each buffer written back.
// When the age counter wraps, renumbering reassigns the ages of all listed slots by rank.
// One transaction is processed at a time; a finished result waits in the output register.
// Reset is synchronous and active low; it frees all slots and needs no clearing pass.
`timescale 1ns / 1ps
module block_buffer_cache_policy #(
    parameter int NUM_SLOTS = bbcp_pkg::NUM_SLOTS_DEF
) (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                s_valid,
    output logic                                s_ready,
    input  bbcp_pkg::in_item_t                  s_data,
    output logic                                m_valid,
    input  logic                                m_ready,
    output bbcp_pkg::out_item_t                 m_data,
    input  logic                                cfg_valid,
    output logic                                cfg_ready,
    input  logic [bbcp_pkg::CFG_INDEX_BITS-1:0] cfg_index,
    input  logic [bbcp_pkg::CFG_DATA_BITS-1:0]  cfg_data
);

    bbcp_pkg::cmd_t  cmd;
    bbcp_pkg::stat_t stat;

    assign cfg_ready = 1'b1;

    bbcp_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .in_op   (s_data.op),
        .s_ready (s_ready),
        .stat    (stat),
        .cmd     (cmd)
    );

    bbcp_datapath #(
        .NUM_SLOTS (NUM_SLOTS)
    ) u_datapath (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_data   (s_data),
        .cfg_valid (cfg_valid),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cmd       (cmd),
        .stat      (stat),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_data    (m_data)
    );

endmodule

// File: rtl/bbcp_ctrl.sv
// Controller state machine that sequences scans, updates, renumbering and flushes.
`timescale 1ns / 1ps
module bbcp_ctrl (
    input  logic            aclk,
    input  logic            aresetn,
    input  logic            s_valid,
    input  logic [1:0]      in_op,
    output logic            s_ready,
    input  bbcp_pkg::stat_t stat,
    output bbcp_pkg::cmd_t  cmd
);

    localparam logic [3:0] S_IDLE   = 4'd0;
    localparam logic [3:0] S_SCAN   = 4'd1;
    localparam logic [3:0] S_DECIDE = 4'd2;
    localparam logic [3:0] S_AGECHK = 4'd3;
    localparam logic [3:0] S_RNLOAD = 4'd4;
    localparam logic [3:0] S_RNCMP  = 4'd5;
    localparam logic [3:0] S_RNCOPY = 4'd6;
    localparam logic [3:0] S_EMIT   = 4'd7;
    localparam logic [3:0] S_FLDEC  = 4'd8;
    localparam logic [3:0] S_FLPUSH = 4'd9;
    localparam logic [3:0] S_FLTAKE = 4'd10;
    localparam logic [3:0] S_FLEND  = 4'd11;

    logic [3:0] state_reg;
    logic [3:0] state_next;

    assign s_ready = (state_reg == S_IDLE);

    always_comb begin
        cmd        = '0;
        state_next = state_reg;
        case (state_reg)
            S_IDLE: begin
                if (s_valid) begin
                    cmd.load      = 1'b1;
                    cmd.scan_init = 1'b1;
                    if (in_op == bbcp_pkg::OP_FLUSH) begin
                        cmd.fl_init = 1'b1;
                        state_next  = S_SCAN;
                    end else if (in_op == bbcp_pkg::OP_REQUEST ||
                                 in_op == bbcp_pkg::OP_RELEASE) begin
                        state_next = S_SCAN;
                    end
                end
            end
            S_SCAN: begin
                cmd.scan_step = 1'b1;
                if (stat.idx_last) begin
                    state_next = (stat.op == bbcp_pkg::OP_FLUSH) ? S_FLDEC : S_DECIDE;
                end
            end
            S_DECIDE: begin
                cmd.apply  = 1'b1;
                state_next = stat.need_age ? S_AGECHK : S_EMIT;
            end
            S_AGECHK: begin
                if (stat.age_wrap) begin
                    cmd.rn_init = 1'b1;
                    state_next  = S_RNLOAD;
                end else begin
                    cmd.age_assign = 1'b1;
                    state_next     = S_EMIT;
                end
            end
            S_RNLOAD: begin
                cmd.rn_load = 1'b1;
                state_next  = S_RNCMP;
            end
            S_RNCMP: begin
                cmd.rn_cmp = 1'b1;
                if (stat.idx_last) begin
                    state_next = stat.ri_last ? S_RNCOPY : S_RNLOAD;
                end
            end
            S_RNCOPY: begin
                cmd.rn_copy = 1'b1;
                if (stat.idx_last) begin
                    state_next = S_AGECHK;
                end
            end
            S_EMIT: begin
                if (stat.out_free) begin
                    cmd.push   = 1'b1;
                    state_next = S_IDLE;
                end
            end
            S_FLDEC: begin
                if (stat.fl_found) begin
                    state_next = stat.fl_pend ? S_FLPUSH : S_FLTAKE;
                end else if (!stat.fl_pass_dirty) begin
                    cmd.fl_pass   = 1'b1;
                    cmd.scan_init = 1'b1;
                    state_next    = S_SCAN;
                end else begin
                    state_next = S_FLEND;
                end
            end
            S_FLPUSH: begin
                if (stat.out_free) begin
                    cmd.fl_push = 1'b1;
                    state_next  = S_FLTAKE;
                end
            end
            S_FLTAKE: begin
                cmd.fl_take   = 1'b1;
                cmd.scan_init = 1'b1;
                state_next    = stat.fl_k_full ? S_FLEND : S_SCAN;
            end
            S_FLEND: begin
                if (stat.out_free) begin
                    cmd.fl_end = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

endmodule

// File: rtl/bbcp_datapath.sv
// Datapath holding the slot tables, scan trackers, counters and the output register.
`timescale 1ns / 1ps
module bbcp_datapath #(
    parameter int NUM_SLOTS = bbcp_pkg::NUM_SLOTS_DEF
) (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  bbcp_pkg::in_item_t                  in_data,
    input  logic                                cfg_valid,
    input  logic [bbcp_pkg::CFG_INDEX_BITS-1:0] cfg_index,
    input  logic [bbcp_pkg::CFG_DATA_BITS-1:0]  cfg_data,
    input  bbcp_pkg::cmd_t                      cmd,
    output bbcp_pkg::stat_t                     stat,
    output logic                                m_valid,
    input  logic                                m_ready,
    output bbcp_pkg::out_item_t                 m_data
);

    localparam int IW = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;
    localparam int CW = $clog2(NUM_SLOTS + 1);
    localparam int HW = CW + bbcp_pkg::MAX_HELD_BITS;
    localparam int BB = bbcp_pkg::BLOCK_BITS;
    localparam int AB = bbcp_pkg::AGE_BITS;
    localparam int RB = bbcp_pkg::REF_BITS;
    localparam int FB = bbcp_pkg::FLUSH_CNT_BITS;
    localparam logic [IW-1:0] LAST_IDX = IW'(NUM_SLOTS - 1);

    logic [BB-1:0] slot_block_reg [NUM_SLOTS];
    logic [RB-1:0] slot_refs_reg  [NUM_SLOTS];
    logic [1:0]    slot_list_reg  [NUM_SLOTS];
    logic [AB-1:0] slot_age_reg   [NUM_SLOTS];
    logic [IW-1:0] rank_reg       [NUM_SLOTS];

    logic [AB-1:0] age_counter_reg;
    logic [CW-1:0] active_count_reg, clean_count_reg, dirty_count_reg;
    logic [bbcp_pkg::MAX_HELD_BITS-1:0] max_held_reg;
    logic          no_local_reg;

    bbcp_pkg::in_item_t  item_reg;
    bbcp_pkg::out_item_t res_reg, m_data_reg;
    logic                m_valid_reg;
    logic [IW-1:0]       idx_reg, target_reg;

    logic          fa_reg, fc_reg, fd_reg, ff_reg, foc_reg, fod_reg;
    logic [IW-1:0] ia_reg, ic_reg, id_reg, ifr_reg, ioc_reg, iod_reg;
    logic [AB-1:0] aa_reg, ac_reg, ad_reg, aoc_reg, aod_reg;
    logic [BB-1:0] boc_reg, bod_reg;

    logic [IW-1:0] ri_reg, acc_reg;
    logic [AB-1:0] agei_reg;
    logic          listedi_reg;
    logic [CW-1:0] n_reg;

    logic [FB-1:0] k_reg;
    logic          pass_dirty_reg, pend_reg, pend_mod_reg;
    logic [BB-1:0] pend_blk_reg;

    logic [1:0]    e_list;
    logic [AB-1:0] e_age;
    logic [BB-1:0] e_blk;
    logic          e_match, idx_last, rn_lt;
    logic          is_req, is_rel, hit_c, hit_d;
    logic [RB-1:0] ra, ra_inc, ra_dec;
    logic [HW-1:0] held, held_max;
    logic          evict_go, evict_clean, ev_c, ev_d;
    logic [CW-1:0] clean_park, dirty_park;
    bbcp_pkg::out_item_t res_calc, fl_item;

    assign e_list   = slot_list_reg[idx_reg];
    assign e_age    = slot_age_reg[idx_reg];
    assign e_blk    = slot_block_reg[idx_reg];
    assign e_match  = (e_blk == item_reg.block_number);
    assign idx_last = (idx_reg == LAST_IDX);
    assign rn_lt    = (e_list != bbcp_pkg::L_FREE) && (e_age < agei_reg);

    assign is_req = (item_reg.op == bbcp_pkg::OP_REQUEST);
    assign is_rel = (item_reg.op == bbcp_pkg::OP_RELEASE);
    assign hit_c  = !no_local_reg && fc_reg;
    assign hit_d  = !no_local_reg && fd_reg && !fc_reg;

    assign ra     = slot_refs_reg[ia_reg];
    assign ra_inc = (ra == '1) ? ra : ra + RB'(1);
    assign ra_dec = (ra == '0) ? ra : ra - RB'(1);

    assign held        = HW'(clean_count_reg) + HW'(dirty_count_reg);
    assign held_max    = HW'(max_held_reg);
    assign evict_go    = (held >= held_max);
    assign evict_clean = (clean_count_reg > dirty_count_reg);
    assign ev_c        = evict_go && evict_clean && foc_reg;
    assign ev_d        = evict_go && !evict_clean && fod_reg;
    assign clean_park  = clean_count_reg - CW'(ev_c) + CW'(!item_reg.dirty);
    assign dirty_park  = dirty_count_reg - CW'(ev_d) + CW'(item_reg.dirty);

    always_comb begin
        res_calc      = '0;
        res_calc.last = 1'b1;
        if (is_req) begin
            if (fa_reg) begin
                res_calc.status    = bbcp_pkg::ST_SHARED_HIT;
                res_calc.ref_count = ra_inc;
            end else if (hit_c) begin
                res_calc.status    = bbcp_pkg::ST_CLEAN_HIT;
                res_calc.ref_count = RB'(1);
            end else if (hit_d) begin
                res_calc.status    = bbcp_pkg::ST_DIRTY_HIT;
                res_calc.dirty_out = 1'b1;
                res_calc.ref_count = RB'(1);
            end else if (ff_reg) begin
                res_calc.status      = bbcp_pkg::ST_FETCHED;
                res_calc.fetch_valid = 1'b1;
                res_calc.fetch_read  = item_reg.read_from_media;
                res_calc.ref_count   = RB'(1);
            end else begin
                res_calc.status = bbcp_pkg::ST_NO_SLOT;
            end
        end else if (is_rel) begin
            if (!fa_reg) begin
                res_calc.status = bbcp_pkg::ST_UNKNOWN;
            end else if (ra_dec != '0) begin
                res_calc.status    = bbcp_pkg::ST_STILL_REF;
                res_calc.ref_count = ra_dec;
            end else if (no_local_reg) begin
                res_calc.status             = bbcp_pkg::ST_WRITTEN;
                res_calc.writeback_valid    = 1'b1;
                res_calc.writeback_block    = item_reg.block_number;
                res_calc.writeback_modified = item_reg.dirty;
            end else begin
                res_calc.status = item_reg.dirty ? bbcp_pkg::ST_PARK_DIRTY
                                                 : bbcp_pkg::ST_PARK_CLEAN;
                if (ev_c) begin
                    res_calc.writeback_valid = 1'b1;
                    res_calc.writeback_block = boc_reg;
                end else if (ev_d) begin
                    res_calc.writeback_valid    = 1'b1;
                    res_calc.writeback_block    = bod_reg;
                    res_calc.writeback_modified = 1'b1;
                end
            end
        end
    end

    always_comb begin
        fl_item                    = '0;
        fl_item.status             = pend_reg ? bbcp_pkg::ST_WRITTEN : bbcp_pkg::ST_FLUSH_EMPTY;
        fl_item.writeback_valid    = pend_reg;
        fl_item.writeback_block    = pend_reg ? pend_blk_reg : '0;
        fl_item.writeback_modified = pend_reg && pend_mod_reg;
        fl_item.last               = cmd.fl_end;
    end

    always_comb begin
        stat               = '0;
        stat.op            = item_reg.op;
        stat.idx_last      = idx_last;
        stat.ri_last       = (ri_reg == LAST_IDX);
        stat.age_wrap      = (age_counter_reg == '1);
        stat.fl_found      = pass_dirty_reg ? fod_reg : foc_reg;
        stat.fl_pend       = pend_reg;
        stat.fl_k_full     = (k_reg == FB'(bbcp_pkg::MAX_OUT - 1));
        stat.fl_pass_dirty = pass_dirty_reg;
        stat.out_free      = !m_valid_reg || m_ready;
        if (is_req) begin
            stat.need_age = fa_reg || hit_c || hit_d || ff_reg;
        end else if (is_rel) begin
            stat.need_age = fa_reg && (ra_dec == '0) && !no_local_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < NUM_SLOTS; i++) begin
                slot_refs_reg[i] <= '0;
                slot_list_reg[i] <= bbcp_pkg::L_FREE;
                slot_age_reg[i]  <= '0;
            end
            age_counter_reg  <= '0;
            active_count_reg <= '0;
            clean_count_reg  <= '0;
            dirty_count_reg  <= '0;
            max_held_reg     <= bbcp_pkg::MAX_HELD_RST;
            no_local_reg     <= 1'b0;
            m_valid_reg      <= 1'b0;
            idx_reg          <= '0;
            fa_reg           <= 1'b0;
            fc_reg           <= 1'b0;
            fd_reg           <= 1'b0;
            ff_reg           <= 1'b0;
            foc_reg          <= 1'b0;
            fod_reg          <= 1'b0;
            ri_reg           <= '0;
            n_reg            <= '0;
            k_reg            <= '0;
            pass_dirty_reg   <= 1'b0;
            pend_reg         <= 1'b0;
        end else begin
            if (cfg_valid) begin
                case (cfg_index)
                    bbcp_pkg::CFG_MAX_HELD: max_held_reg <= cfg_data[bbcp_pkg::MAX_HELD_BITS-1:0];
                    bbcp_pkg::CFG_NO_LOCAL: no_local_reg <= cfg_data[0];
                    default: ;
                endcase
            end

            if (cmd.load) begin
                item_reg <= in_data;
            end

            if (cmd.scan_step) begin
                if (e_list == bbcp_pkg::L_ACTIVE && e_match && (!fa_reg || e_age > aa_reg)) begin
                    fa_reg <= 1'b1;
                    ia_reg <= idx_reg;
                    aa_reg <= e_age;
                end
                if (e_list == bbcp_pkg::L_CLEAN && e_match && (!fc_reg || e_age > ac_reg)) begin
                    fc_reg <= 1'b1;
                    ic_reg <= idx_reg;
                    ac_reg <= e_age;
                end
                if (e_list == bbcp_pkg::L_DIRTY && e_match && (!fd_reg || e_age > ad_reg)) begin
                    fd_reg <= 1'b1;
                    id_reg <= idx_reg;
                    ad_reg <= e_age;
                end
                if (e_list == bbcp_pkg::L_FREE && !ff_reg) begin
                    ff_reg  <= 1'b1;
                    ifr_reg <= idx_reg;
                end
                if (e_list == bbcp_pkg::L_CLEAN && (!foc_reg || e_age < aoc_reg)) begin
                    foc_reg <= 1'b1;
                    ioc_reg <= idx_reg;
                    aoc_reg <= e_age;
                    boc_reg <= e_blk;
                end
                if (e_list == bbcp_pkg::L_DIRTY && (!fod_reg || e_age < aod_reg)) begin
                    fod_reg <= 1'b1;
                    iod_reg <= idx_reg;
                    aod_reg <= e_age;
                    bod_reg <= e_blk;
                end
                idx_reg <= idx_last ? '0 : idx_reg + IW'(1);
            end

            if (cmd.apply) begin
                res_reg <= res_calc;
                if (is_req) begin
                    if (fa_reg) begin
                        slot_refs_reg[ia_reg] <= ra_inc;
                        target_reg            <= ia_reg;
                    end else if (hit_c) begin
                        slot_refs_reg[ic_reg] <= RB'(1);
                        slot_list_reg[ic_reg] <= bbcp_pkg::L_ACTIVE;
                        clean_count_reg       <= clean_count_reg - CW'(1);
                        active_count_reg      <= active_count_reg + CW'(1);
                        target_reg            <= ic_reg;
                    end else if (hit_d) begin
                        slot_refs_reg[id_reg] <= RB'(1);
                        slot_list_reg[id_reg] <= bbcp_pkg::L_ACTIVE;
                        dirty_count_reg       <= dirty_count_reg - CW'(1);
                        active_count_reg      <= active_count_reg + CW'(1);
                        target_reg            <= id_reg;
                    end else if (ff_reg) begin
                        slot_block_reg[ifr_reg] <= item_reg.block_number;
                        slot_refs_reg[ifr_reg]  <= RB'(1);
                        slot_list_reg[ifr_reg]  <= bbcp_pkg::L_ACTIVE;
                        active_count_reg        <= active_count_reg + CW'(1);
                        target_reg              <= ifr_reg;
                    end
                end else if (is_rel && fa_reg) begin
                    slot_refs_reg[ia_reg] <= ra_dec;
                    if (ra_dec == '0) begin
                        if (active_count_reg != '0) begin
                            active_count_reg <= active_count_reg - CW'(1);
                        end
                        if (no_local_reg) begin
                            slot_list_reg[ia_reg] <= bbcp_pkg::L_FREE;
                        end else begin
                            if (ev_c) begin
                                slot_list_reg[ioc_reg] <= bbcp_pkg::L_FREE;
                            end
                            if (ev_d) begin
                                slot_list_reg[iod_reg] <= bbcp_pkg::L_FREE;
                            end
                            slot_list_reg[ia_reg] <= item_reg.dirty ? bbcp_pkg::L_DIRTY
                                                                    : bbcp_pkg::L_CLEAN;
                            clean_count_reg <= clean_park;
                            dirty_count_reg <= dirty_park;
                            target_reg      <= ia_reg;
                        end
                    end
                end
            end

            if (cmd.age_assign) begin
                slot_age_reg[target_reg] <= age_counter_reg;
                age_counter_reg          <= age_counter_reg + AB'(1);
            end

            if (cmd.rn_init) begin
                ri_reg <= '0;
                n_reg  <= '0;
            end
            if (cmd.rn_load) begin
                agei_reg    <= slot_age_reg[ri_reg];
                listedi_reg <= (slot_list_reg[ri_reg] != bbcp_pkg::L_FREE);
                idx_reg     <= '0;
                acc_reg     <= '0;
            end
            if (cmd.rn_cmp) begin
                if (idx_last) begin
                    rank_reg[ri_reg] <= acc_reg + IW'(rn_lt);
                    if (listedi_reg) begin
                        n_reg <= n_reg + CW'(1);
                    end
                    ri_reg  <= ri_reg + IW'(1);
                    idx_reg <= '0;
                end else begin
                    acc_reg <= acc_reg + IW'(rn_lt);
                    idx_reg <= idx_reg + IW'(1);
                end
            end
            if (cmd.rn_copy) begin
                if (e_list != bbcp_pkg::L_FREE) begin
                    slot_age_reg[idx_reg] <= AB'(rank_reg[idx_reg]);
                end
                if (idx_last) begin
                    idx_reg         <= '0;
                    age_counter_reg <= AB'(n_reg);
                end else begin
                    idx_reg <= idx_reg + IW'(1);
                end
            end

            if (cmd.fl_init) begin
                k_reg          <= '0;
                pass_dirty_reg <= 1'b0;
                pend_reg       <= 1'b0;
            end
            if (cmd.fl_pass) begin
                pass_dirty_reg <= 1'b1;
            end
            if (cmd.fl_take) begin
                if (pass_dirty_reg) begin
                    slot_list_reg[iod_reg] <= bbcp_pkg::L_FREE;
                    dirty_count_reg        <= dirty_count_reg - CW'(1);
                    pend_blk_reg           <= bod_reg;
                end else begin
                    slot_list_reg[ioc_reg] <= bbcp_pkg::L_FREE;
                    clean_count_reg        <= clean_count_reg - CW'(1);
                    pend_blk_reg           <= boc_reg;
                end
                pend_reg     <= 1'b1;
                pend_mod_reg <= pass_dirty_reg;
                k_reg        <= k_reg + FB'(1);
            end

            if (cmd.scan_init) begin
                idx_reg <= '0;
                fa_reg  <= 1'b0;
                fc_reg  <= 1'b0;
                fd_reg  <= 1'b0;
                ff_reg  <= 1'b0;
                foc_reg <= 1'b0;
                fod_reg <= 1'b0;
            end

            if (cmd.push) begin
                m_data_reg  <= res_reg;
                m_valid_reg <= 1'b1;
            end else if (cmd.fl_push || cmd.fl_end) begin
                m_data_reg  <= fl_item;
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

endmodule

// File: rtl/bbcp_checker.sv
// Port-level checker for the block buffer cache policy and its bind statement.
`timescale 1ns / 1ps
module bbcp_checker (
    input logic                aclk,
    input logic                aresetn,
    input logic                m_valid,
    input logic                m_ready,
    input bbcp_pkg::out_item_t m_data
);

    // A stalled result transaction keeps its payload.
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_data))
        else $error("result changed while stalled");

    a_fetch: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && (m_data.status != bbcp_pkg::ST_FETCHED) |-> !m_data.fetch_valid)
        else $error("fetch issued without a miss");

    a_wb: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_data.writeback_valid |->
            (m_data.status == bbcp_pkg::ST_WRITTEN || m_data.status == bbcp_pkg::ST_PARK_CLEAN ||
             m_data.status == bbcp_pkg::ST_PARK_DIRTY))
        else $error("write-back on a result that cannot carry one");

    a_single: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_data.status != bbcp_pkg::ST_WRITTEN |-> m_data.last)
        else $error("only flush write-backs may be followed by more results");

endmodule

bind block_buffer_cache_policy bbcp_checker u_bbcp_checker (.*);
